>>> rtl/core/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// lpfr_pkg
// Types and constants shared by the length-prefixed frame receiver core.
// ----------------------------------------------------------------------------
package lpfr_pkg;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_CONSUME = 2'd2,
        OP_READ    = 2'd3
    } lpfr_op_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W      = 1;
    localparam int unsigned CFG_DATA_W       = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH   = 1'd1;

    localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0]  MAX_LENGTH_RESET   = 8'd200;

    // frame layout
    localparam logic [7:0]  HEADER_BYTES   = 8'd3;
    localparam logic [7:0]  POSITION_LIMIT = 8'd255;
    localparam logic [15:0] IDLE_TICKS_MAX = 16'hFFFF;

    typedef struct packed {
        lpfr_op_t    operation;
        logic [7:0]  rx_byte;
        logic [6:0]  read_index;
    } lpfr_in_t;

    typedef struct packed {
        logic        frame_ready;
        logic        frame_complete;
        logic [7:0]  axis_byte;
        logic [7:0]  command_byte;
        logic [7:0]  value_length;
        logic [7:0]  read_data;
    } lpfr_out_t;

    typedef struct packed {
        logic [15:0] idle_timeout;
        logic [7:0]  length_limit;
    } lpfr_cfg_t;

endpackage

>>> rtl/core/lpfr_parse.sv
// ----------------------------------------------------------------------------
// lpfr_parse
// Frame parser state, value store and the first result register.
// ----------------------------------------------------------------------------
module lpfr_parse
    import lpfr_pkg::*;
#(
    parameter int unsigned VALUE_STORE_DEPTH = 128
)(
    input  logic       clk,
    input  logic       rst_n,
    input  lpfr_cfg_t  cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  lpfr_in_t   in_data,
    output logic       res_valid,
    input  logic       res_ready,
    output lpfr_out_t  res_data
);

    localparam int unsigned ADDR_W =
        (VALUE_STORE_DEPTH > 1) ? $clog2(VALUE_STORE_DEPTH) : 1;
    localparam logic [8:0] DEPTH_9 = 9'(VALUE_STORE_DEPTH);

    logic [7:0]  pos_reg,     pos_next;
    logic [7:0]  axis_reg,    axis_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  length_reg,  length_next;
    logic        ready_reg,   ready_next;
    logic [15:0] idle_reg,    idle_next;
    logic        s1_valid_reg, s1_valid_next;

    // first result register
    logic        s1_complete_reg;
    logic        s1_hit_reg;
    logic        s1_ready_reg;
    logic [7:0]  s1_axis_reg;
    logic [7:0]  s1_command_reg;
    logic [7:0]  s1_length_reg;
    logic [7:0]  rd_data_reg;

    logic [7:0]  value_mem [VALUE_STORE_DEPTH];

    logic              accept;
    logic              complete;
    logic [7:0]        pos0;
    logic [7:0]        slot;
    logic [7:0]        pos_inc;
    logic [7:0]        count;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        idx8;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_hit;

    assign in_ready = !s1_valid_reg || res_ready;
    assign accept   = in_valid && in_ready;

    assign pos0    = (idle_reg >= cfg.idle_timeout) ? 8'd0 : pos_reg;
    assign slot    = pos0 - HEADER_BYTES;
    assign wr_addr = slot[ADDR_W-1:0];
    assign pos_inc = (pos0 < POSITION_LIMIT) ? pos0 + 8'd1 : POSITION_LIMIT;
    assign count   = pos_inc - HEADER_BYTES;
    assign idx8    = {1'b0, in_data.read_index};
    assign rd_addr = idx8[ADDR_W-1:0];
    assign rd_hit  = (in_data.operation == OP_READ) && ({1'b0, idx8} < DEPTH_9);

    always_comb
    begin
        pos_next     = pos_reg;
        axis_next    = axis_reg;
        command_next = command_reg;
        length_next  = length_reg;
        ready_next   = ready_reg;
        idle_next    = idle_reg;
        complete     = 1'b0;
        mem_we       = 1'b0;
        if (accept)
        begin
            case (in_data.operation)
                OP_BYTE:
                begin
                    idle_next = '0;
                    pos_next  = pos0;
                    if (!ready_reg)
                    begin
                        case (pos0)
                            8'd0:
                            begin
                                axis_next = in_data.rx_byte;
                                pos_next  = 8'd1;
                            end
                            8'd1:
                            begin
                                command_next = in_data.rx_byte;
                                pos_next     = 8'd2;
                            end
                            8'd2:
                            begin
                                length_next = in_data.rx_byte;
                                if (in_data.rx_byte > cfg.length_limit)
                                begin
                                    pos_next = 8'd0;
                                end
                                else if (in_data.rx_byte == 8'd0)
                                begin
                                    // empty frame ends on its length byte
                                    ready_next = 1'b1;
                                    complete   = 1'b1;
                                    pos_next   = 8'd0;
                                end
                                else
                                begin
                                    pos_next = HEADER_BYTES;
                                end
                            end
                            default:
                            begin
                                mem_we   = ({1'b0, slot} < DEPTH_9);
                                pos_next = pos_inc;
                                if ((count >= length_reg) || (pos_inc >= POSITION_LIMIT))
                                begin
                                    // oversized frames end without the ready flag
                                    if (({1'b0, length_reg} <= DEPTH_9) &&
                                        (count >= length_reg))
                                    begin
                                        ready_next = 1'b1;
                                        complete   = 1'b1;
                                    end
                                    pos_next = 8'd0;
                                end
                            end
                        endcase
                    end
                end
                OP_TICK:
                begin
                    if (idle_reg != IDLE_TICKS_MAX)
                    begin
                        idle_next = idle_reg + 16'd1;
                    end
                end
                OP_CONSUME:
                begin
                    ready_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            axis_reg     <= '0;
            command_reg  <= '0;
            length_reg   <= '0;
            ready_reg    <= 1'b0;
            idle_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            axis_reg     <= axis_next;
            command_reg  <= command_next;
            length_reg   <= length_next;
            ready_reg    <= ready_next;
            idle_reg     <= idle_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_complete_reg <= complete;
            s1_hit_reg      <= rd_hit;
            s1_ready_reg    <= ready_next;
            s1_axis_reg     <= axis_next;
            s1_command_reg  <= command_next;
            s1_length_reg   <= length_next;
        end
    end

    // value store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            value_mem[wr_addr] <= in_data.rx_byte;
        end
        if (accept && rd_hit)
        begin
            rd_data_reg <= value_mem[rd_addr];
        end
    end

    assign res_valid               = s1_valid_reg;
    assign res_data.frame_ready    = s1_ready_reg;
    assign res_data.frame_complete = s1_complete_reg;
    assign res_data.axis_byte      = s1_axis_reg;
    assign res_data.command_byte   = s1_command_reg;
    assign res_data.value_length   = s1_length_reg;
    assign res_data.read_data      = s1_hit_reg ? rd_data_reg : 8'd0;

endmodule

>>> rtl/core/lpfr_skid.sv
// ----------------------------------------------------------------------------
// lpfr_skid
// Output register with a skid entry; upstream ready comes from a flop.
// ----------------------------------------------------------------------------
module lpfr_skid
    import lpfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  lpfr_out_t  up_data,
    output logic       out_valid,
    input  logic       out_ready,
    output lpfr_out_t  out_data
);

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    lpfr_out_t main_reg,       main_next;
    lpfr_out_t skid_reg,       skid_next;

    assign up_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (out_ready || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = up_data;
                main_valid_next = up_valid;
            end
        end
        else if (up_valid && !skid_valid_reg)
        begin
            skid_next       = up_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

>>> rtl/core/length_prefixed_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_core
// Byte-stream frame parser with value store, tick timeout and read access.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_ready is high: a received byte, an idle
// tick, a frame consume or a read of the value store, and returns one result
// per item, in order, via the first result register and the output register;
// the parser and the one-write one-read value store keep up with every item.
// in_ready comes from flops only, so a stalled output holds up the input
// after the skid entry and the first result register have filled. Frames are
// axis, command, length and then length value bytes; configuration writes on
// cfg_* take effect at the next edge and belong in idle periods.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_core
    import lpfr_pkg::*;
#(
    parameter int unsigned VALUE_STORE_DEPTH = 128
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lpfr_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lpfr_out_t              out_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [15:0] idle_timeout_reg;
    logic [7:0]  max_length_reg;
    lpfr_cfg_t   cfg;

    // parser to output buffer
    logic        res_valid;
    logic        res_ready;
    lpfr_out_t   res_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= IDLE_TIMEOUT_RESET;
            max_length_reg   <= MAX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                CFG_MAX_LENGTH:   max_length_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.idle_timeout = idle_timeout_reg;
    assign cfg.length_limit = max_length_reg;

    // parser, value store and first result register
    lpfr_parse #(
        .VALUE_STORE_DEPTH (VALUE_STORE_DEPTH)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // output register plus skid entry
    lpfr_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (res_valid),
        .up_ready  (res_ready),
        .up_data   (res_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // a completed frame always leaves the ready flag set
    a_complete_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_complete |-> out_data.frame_ready)
        else $error("frame_complete without frame_ready");

    // a flagged frame never claims more value bytes than the store holds
    a_complete_fits_store: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_complete |->
            ({1'b0, out_data.value_length} <= 9'(VALUE_STORE_DEPTH)))
        else $error("flagged frame longer than value store");

    // with nothing waiting at the output the input side must be open
    a_empty_output_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");
`endif

endmodule

>>> verif/lpfr_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpfr_frame_checker
// Watches both channels and the configuration port of the frame receiver,
// works out the result of every input transfer and checks every output
// transfer against the oldest outstanding result.
// ----------------------------------------------------------------------------
module lpfr_frame_checker
    import lpfr_pkg::*;
#(
    parameter int unsigned VALUE_STORE_DEPTH = 128
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  lpfr_in_t                     in_data,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  lpfr_out_t                    out_data,
    input  logic                         cfg_write,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output int                           mismatches,
    output int                           pending_results,
    output logic [VALUE_STORE_DEPTH-1:0] stored_mask
);

    localparam int unsigned ADDR_W =
        (VALUE_STORE_DEPTH > 1) ? $clog2(VALUE_STORE_DEPTH) : 1;
    localparam logic [8:0] DEPTH_9 = 9'(VALUE_STORE_DEPTH);

    logic [15:0] idle_timeout_reg;
    logic [7:0]  max_length_reg;

    logic [7:0]  rx_position;
    logic [7:0]  axis_latch;
    logic [7:0]  command_latch;
    logic [7:0]  length_latch;
    logic [7:0]  value_mem [VALUE_STORE_DEPTH];
    logic [VALUE_STORE_DEPTH-1:0] value_written;
    logic        frame_waiting;
    logic [15:0] idle_count;

    lpfr_out_t   predicted_results [$];

    // parser update for one item, returns the result it produces
    function automatic lpfr_out_t advance_parser(lpfr_in_t item);
        lpfr_out_t   res;
        logic [7:0]  pos;
        logic [7:0]  slot;
        logic        closing;
        logic        done;
        res     = '0;
        done    = 1'b0;
        closing = 1'b0;
        case (item.operation)
            OP_BYTE: begin
                if (idle_count >= idle_timeout_reg)
                    rx_position = '0;
                idle_count = '0;
                if (!frame_waiting) begin
                    pos = rx_position;
                    if (pos == 8'd0) begin
                        axis_latch  = item.rx_byte;
                        rx_position = 8'd1;
                    end else if (pos == 8'd1) begin
                        command_latch = item.rx_byte;
                        rx_position   = 8'd2;
                    end else if (pos == 8'd2) begin
                        length_latch = item.rx_byte;
                        if (item.rx_byte > max_length_reg)
                            rx_position = '0;
                        else begin
                            pos     = HEADER_BYTES;
                            closing = 1'b1;
                        end
                    end else begin
                        slot = pos - HEADER_BYTES;
                        if ({1'b0, slot} < DEPTH_9) begin
                            value_mem[slot[ADDR_W-1:0]]     = item.rx_byte;
                            value_written[slot[ADDR_W-1:0]] = 1'b1;
                        end
                        if (pos < POSITION_LIMIT)
                            pos = pos + 8'd1;
                        closing = 1'b1;
                    end
                    if (closing) begin
                        slot = pos - HEADER_BYTES;
                        if (slot >= length_latch || pos >= POSITION_LIMIT) begin
                            // oversized frames run to the end but are never flagged
                            if ({1'b0, length_latch} <= DEPTH_9 && slot >= length_latch) begin
                                frame_waiting = 1'b1;
                                done          = 1'b1;
                            end
                            pos = 8'd0;
                        end
                        rx_position = pos;
                    end
                end
            end
            OP_TICK: begin
                if (idle_count != IDLE_TICKS_MAX)
                    idle_count++;
            end
            OP_CONSUME: begin
                frame_waiting = 1'b0;
            end
            OP_READ: begin
                if ({2'b0, item.read_index} < DEPTH_9)
                    res.read_data = value_mem[ADDR_W'(item.read_index)];
            end
            default: ;
        endcase
        res.frame_ready    = frame_waiting;
        res.frame_complete = done;
        res.axis_byte      = axis_latch;
        res.command_byte   = command_latch;
        res.value_length   = length_latch;
        return res;
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        lpfr_out_t want;
        if (!rst_n) begin
            idle_timeout_reg = IDLE_TIMEOUT_RESET;
            max_length_reg   = MAX_LENGTH_RESET;
            rx_position      = '0;
            axis_latch       = '0;
            command_latch    = '0;
            length_latch     = '0;
            value_written    = '0;
            frame_waiting    = 1'b0;
            idle_count       = '0;
            predicted_results.delete();
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_IDLE_TIMEOUT: idle_timeout_reg = cfg_data;
                    CFG_MAX_LENGTH:   max_length_reg   = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, out_data);
                end else begin
                    want = predicted_results.pop_front();
                    check_field("frame_ready", 8'(want.frame_ready), 8'(out_data.frame_ready));
                    check_field("frame_complete", 8'(want.frame_complete),
                                8'(out_data.frame_complete));
                    check_field("axis_byte", want.axis_byte, out_data.axis_byte);
                    check_field("command_byte", want.command_byte, out_data.command_byte);
                    check_field("value_length", want.value_length, out_data.value_length);
                    check_field("read_data", want.read_data, out_data.read_data);
                end
            end
            if (in_valid && in_ready)
                predicted_results.push_back(advance_parser(in_data));
        end
        pending_results <= predicted_results.size();
        stored_mask     <= value_written;
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the length-prefixed frame receiver core. A short
// directed sequence is followed by random frame traffic under several
// timeout and length settings; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top
    import lpfr_pkg::*;
();

    localparam int unsigned STORE_DEPTH = 128;
    localparam int unsigned STORE_ADDR_W = $clog2(STORE_DEPTH);
    localparam int HOLD_OFF_CYCLES = 400;    // long receiver stall to back up the core
    localparam int DRAIN_LIMIT     = 2000;   // bound on waiting for outstanding results

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    lpfr_in_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    lpfr_out_t              out_data;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     mismatches;
    int                     pending_results;
    logic [STORE_DEPTH-1:0] stored_mask;

    // stimulus knobs
    logic tx_idle_on;
    logic rx_idle_on;
    int   hold_requests;
    int   sent_items;
    int   cur_timeout;
    int   cur_max;

    length_prefixed_frame_receiver_core #(
        .VALUE_STORE_DEPTH(STORE_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lpfr_frame_checker #(
        .VALUE_STORE_DEPTH(STORE_DEPTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .stored_mask     (stored_mask)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard stop in case a transfer or a result never comes
    initial
    begin
        #20_000_000;
        $display("** length_prefixed_frame_receiver_core: FAILED **");
        $finish;
    end

    // output side: random back-pressure, plus a long hold-off on request
    initial
    begin
        int holds_served;
        holds_served = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= !rx_idle_on || ($urandom_range(99) >= 30);
            end
        end
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic offer(input lpfr_op_t op, input logic [7:0] data_byte,
                         input logic [6:0] index);
        lpfr_in_t item;
        item.operation  = op;
        item.rx_byte    = data_byte;
        item.read_index = index;
        while (tx_idle_on && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
    endtask

    task automatic put_byte(input logic [7:0] data_byte);
        offer(OP_BYTE, data_byte, 7'($urandom));
    endtask

    task automatic put_tick();
        offer(OP_TICK, 8'($urandom), 7'($urandom));
    endtask

    task automatic put_consume();
        offer(OP_CONSUME, 8'($urandom), 7'($urandom));
    endtask

    // reads only ever target written entries; an unwritten pick is replaced by
    // the next written one upward, wrapping round, or by a tick if none is written
    task automatic put_read(input int idx);
        int pick;
        pick = -1;
        for (int k = 0; k < STORE_DEPTH; k++)
            if (pick < 0 && stored_mask[STORE_ADDR_W'((idx + k) % STORE_DEPTH)])
                pick = (idx + k) % STORE_DEPTH;
        if (pick < 0)
            put_tick();
        else
            offer(OP_READ, 8'($urandom), 7'(pick));
    endtask

    // header with random axis and command, then nvals random value bytes
    // with a few reads mixed in
    task automatic put_frame(input int len, input int nvals);
        put_byte(8'($urandom));
        put_byte(8'($urandom));
        put_byte(8'(len));
        for (int v = 0; v < nvals; v++)
        begin
            if ($urandom_range(99) < 8)
                put_read($urandom_range(STORE_DEPTH - 1));
            put_byte(8'($urandom));
        end
    endtask

    // mostly short lengths; now and then one around the store size or up to the limit
    function automatic int pick_length();
        int len;
        if ($urandom_range(19) == 0)
        begin
            case ($urandom_range(3))
                0:       len = STORE_DEPTH - 1;
                1:       len = STORE_DEPTH;
                2:       len = STORE_DEPTH + 1;
                default: len = $urandom_range(cur_max);
            endcase
            if (len > cur_max)
                len = $urandom_range(cur_max);
        end
        else
        begin
            len = $urandom_range(cur_max < 10 ? cur_max : 10);
        end
        return len;
    endfunction

    // both registers, one write each on consecutive edges
    task automatic program_receiver(input int timeout, input int maxlen);
        cur_timeout = timeout;
        cur_max     = maxlen;
        cfg_write <= 1'b1;
        cfg_index <= CFG_IDLE_TIMEOUT;
        cfg_data  <= CFG_DATA_W'(timeout);
        @(posedge clk);
        cfg_index <= CFG_MAX_LENGTH;
        cfg_data  <= CFG_DATA_W'(maxlen);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // random traffic: mostly well-formed frames, plus reads, tick bursts,
    // consumes, truncated frames and over-length headers
    task automatic run_traffic(input int n);
        int stop_at;
        int sel;
        int len;
        int reps;
        stop_at = sent_items + n;
        while (sent_items < stop_at)
        begin
            sel = $urandom_range(99);
            if (sel < 50)
            begin
                if ($urandom_range(9) < 8)
                    put_consume();
                len = pick_length();
                put_frame(len, len);
            end
            else if (sel < 65)
            begin
                reps = $urandom_range(3, 1);
                repeat (reps) put_read($urandom_range(STORE_DEPTH - 1));
            end
            else if (sel < 75)
            begin
                // ticks up to just past the timeout, at most 30, then a byte that may restart
                reps = $urandom_range(cur_timeout + 2 > 30 ? 30 : cur_timeout + 2);
                repeat (reps) put_tick();
                put_byte(8'($urandom));
            end
            else if (sel < 85)
            begin
                put_consume();
            end
            else if (sel < 93)
            begin
                len = pick_length();
                put_frame(len, $urandom_range(len));
            end
            else if (cur_max < 255)
            begin
                put_frame($urandom_range(255, cur_max + 1), 0);
            end
            else
            begin
                repeat ($urandom_range(4, 1)) put_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_requests = 0;
        sent_items    = 0;
        cur_timeout   = int'(IDLE_TIMEOUT_RESET);
        cur_max       = int'(MAX_LENGTH_RESET);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with a short timeout so that a restart is cheap to reach
        program_receiver(3, 200);
        put_consume();                  // nothing waiting, no effect
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h00);                // zero length completes on the length byte
        put_byte(8'hAA);                // dropped while the frame waits
        put_consume();
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'h03);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h5A);
        put_read(0);
        put_read(1);
        put_read(2);
        put_consume();
        put_byte(8'h12);
        put_byte(8'h34);
        put_byte(8'd201);               // above the length limit, frame aborted
        put_byte(8'h56);
        repeat (3) put_tick();
        put_byte(8'h78);                // idle timeout reached, taken as a new axis
        put_byte(8'h9A);
        put_byte(8'h00);
        wait_drained();

        // default settings; an oversized frame fills the whole store first,
        // then halfway through the receiver holds off while transfers keep coming
        program_receiver(1000, 200);
        put_consume();
        put_frame(200, 200);
        run_traffic(60);
        hold_requests <= hold_requests + 1;
        run_traffic(60);
        wait_drained();

        // largest length limit, first half with no idling on either side
        program_receiver(20, 255);
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        run_traffic(60);
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        run_traffic(60);
        wait_drained();

        // zero timeout restarts on every byte, zero length limit
        program_receiver(0, 0);
        run_traffic(50);
        wait_drained();

        // largest timeout, never reached by the short tick bursts
        program_receiver(65535, STORE_DEPTH);
        run_traffic(80);
        wait_drained();

        // small settings; the sender pauses midway until all results are back
        program_receiver(5, 16);
        run_traffic(50);
        wait_drained();
        run_traffic(50);
        wait_drained();
        repeat (20) @(posedge clk);

        if (mismatches == 0 && pending_results == 0)
            $display("** length_prefixed_frame_receiver_core: PASSED **");
        else
            $display("** length_prefixed_frame_receiver_core: FAILED **");
        $finish;
    end

endmodule

>>> length_prefixed_frame_receiver_core.f
rtl/core/lpfr_pkg.sv
rtl/core/lpfr_parse.sv
rtl/core/lpfr_skid.sv
rtl/core/length_prefixed_frame_receiver_core.sv
verif/lpfr_frame_checker.sv
verif/tb_top.sv
